// File: rtl/assert_macros.svh
// Assertion macros shared by the codec modules; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside reset.
`define UPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("upc assertion failed");

// Checks that an expression is never true outside reset.
`define UPC_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("upc forbidden condition seen");

`else

`define UPC_ASSERT(lbl, clk, rst_n, prop)
`define UPC_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: rtl/upc_pkg.sv
// Types, character constants and helper functions of the URL percent codec.
`timescale 1ns / 1ps

package upc_pkg;

  // Input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } upc_in_t;

  // Result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       escape_error;
  } upc_out_t;

  // Queue entry: one byte to emit as is, or one byte to emit as a three-byte escape.
  typedef struct packed {
    logic       triple;
    logic [7:0] data;
    logic       last;
    logic       err;
  } upc_op_t;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  // Value of a hex digit byte; non-digits wrap modulo 256 relative to 'A'.
  function automatic logic [7:0] digit_value(input logic [7:0] x);
    if (x >= CH_0 && x <= CH_9) begin
      return x - CH_0;
    end
    return x - CH_UA + HEX_TEN;
  endfunction

  // Upper-case hex character of a nibble.
  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if ({4'b0, n} > 8'd9) begin
      return {4'b0, n} - HEX_TEN + CH_UA;
    end
    return {4'b0, n} + CH_0;
  endfunction

  // Bytes that pass through the encoder unchanged.
  function automatic logic is_unreserved(input logic [7:0] c);
    return (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT) ||
           (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_UA && c <= CH_UZ);
  endfunction

endpackage

// File: rtl/upc_fifo.sv
// Short queue of classified operations between the front and back parts.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upc_fifo
  import upc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  upc_op_t push_data,
  input  logic    pop,
  output upc_op_t pop_data,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  upc_op_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer advance with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `UPC_NEVER(a_fifo_overflow, clk, rst_n, push && full)

endmodule

// File: rtl/upc_front.sv
// Front part: holds the mode, accepts input words and classifies each byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upc_front
  import upc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  input  logic    in_valid,
  output logic    in_stall,
  input  upc_in_t in_data,
  input  logic    q_full,
  output logic    q_push,
  output upc_op_t q_data
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic       mode_r, mode_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] hi_nib_r, hi_nib_nxt;
  logic       accept;
  logic [7:0] c;
  logic [7:0] dval;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign c        = in_data.data_byte;
  assign dval     = digit_value(c);

  // Classification of the accepted byte and escape tracking.
  always_comb begin
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    hi_nib_nxt = hi_nib_r;
    q_push     = 1'b0;
    q_data     = '{triple: 1'b0, data: c, last: in_data.last_in, err: 1'b0};
    if (cfg_we) begin
      mode_nxt   = cfg_wdata;
      phase_nxt  = PH_IDLE;
      hi_nib_nxt = 4'd0;
    end else if (accept) begin
      if (mode_r == MODE_ENCODE) begin
        q_push        = 1'b1;
        q_data.triple = !is_unreserved(c);
      end else begin
        case (phase_r)
          PH_PCT: begin
            if (in_data.last_in) begin
              phase_nxt  = PH_IDLE;
              hi_nib_nxt = 4'd0;
              q_push     = 1'b1;
              q_data     = '{triple: 1'b0, data: 8'd0, last: 1'b1, err: 1'b1};
            end else begin
              hi_nib_nxt = dval[3:0];
              phase_nxt  = PH_DIGIT;
            end
          end
          PH_DIGIT: begin
            phase_nxt   = PH_IDLE;
            hi_nib_nxt  = 4'd0;
            q_push      = 1'b1;
            q_data.data = {hi_nib_r, 4'd0} | dval;
          end
          default: begin
            phase_nxt = PH_IDLE;
            if (c == CH_PCT) begin
              if (in_data.last_in) begin
                hi_nib_nxt = 4'd0;
                q_push     = 1'b1;
                q_data     = '{triple: 1'b0, data: 8'd0, last: 1'b1, err: 1'b1};
              end else begin
                phase_nxt = PH_PCT;
              end
            end else begin
              q_push = 1'b1;
              if (c == CH_PLUS) begin
                q_data.data = CH_SPACE;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ENCODE;
      phase_r  <= PH_IDLE;
      hi_nib_r <= 4'd0;
    end else begin
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      hi_nib_r <= hi_nib_nxt;
    end
  end

  `UPC_ASSERT(a_digit_after_pct, clk, rst_n, (phase_r == PH_DIGIT) |-> ($past(phase_r) == PH_PCT || $past(phase_r) == PH_DIGIT))

endmodule

// File: rtl/upc_back.sv
// Back part: drains the queue to the result register, one word per unstalled cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upc_back
  import upc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  upc_op_t  q_data,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output upc_out_t out_data
);

  logic       out_valid_r, out_valid_nxt;
  upc_out_t   out_data_r, out_data_nxt;
  logic [1:0] rem_r, rem_nxt;
  logic [7:0] cur_r, cur_nxt;
  logic       cur_last_r, cur_last_nxt;
  logic       advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign advance   = !out_valid_r || !out_stall;

  // Emit the remaining hex digits of an escape, else load the next queue entry.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rem_nxt       = rem_r;
    cur_nxt       = cur_r;
    cur_last_nxt  = cur_last_r;
    q_pop         = 1'b0;
    if (advance) begin
      if (rem_r == 2'd2) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: nibble_char(cur_r[7:4]), out_last: 1'b0,
                          escape_error: 1'b0};
        rem_nxt       = 2'd1;
      end else if (rem_r == 2'd1) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: nibble_char(cur_r[3:0]), out_last: cur_last_r,
                          escape_error: 1'b0};
        rem_nxt       = 2'd0;
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        cur_nxt       = q_data.data;
        cur_last_nxt  = q_data.last;
        if (q_data.triple) begin
          out_data_nxt = '{out_byte: CH_PCT, out_last: 1'b0, escape_error: 1'b0};
          rem_nxt      = 2'd2;
        end else begin
          out_data_nxt = '{out_byte: q_data.data, out_last: q_data.last,
                           escape_error: q_data.err};
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rem_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cur_r      <= cur_nxt;
    cur_last_r <= cur_last_nxt;
  end

  `UPC_ASSERT(a_rem_has_word, clk, rst_n, (rem_r != 2'd0) |-> out_valid_r)
  `UPC_ASSERT(a_escape_starts_pct, clk, rst_n, (q_pop && q_data.triple) |=> (out_data_r.out_byte == CH_PCT))
  `UPC_ASSERT(a_error_word_form, clk, rst_n, (out_valid_r && out_data_r.escape_error) |-> (out_data_r.out_last && out_data_r.out_byte == 8'd0))

endmodule

// File: rtl/url_percent_codec.sv
// An input byte's first result word passes through the queue and then the result register.
// Throughput: one byte per cycle when decoding or passing unreserved bytes through,
// unless the queue is full. An escaped byte in encode mode yields three result words.
// A queue of QUEUE_DEPTH entries sits between intake and the result register.
// Synchronous active-low reset selects encode mode, leaves escape state idle and empties all.
`timescale 1ns / 1ps

module url_percent_codec
  import upc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_stall,
  input  upc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output upc_out_t out_data
);

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  upc_op_t q_wdata;
  upc_op_t q_rdata;

  // Intake and classification.
  upc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Operation queue.
  upc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Result generation.
  upc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: test/tb.sv
// Self-checking testbench for the URL percent codec: directed table, then random records.
`timescale 1ns / 1ps

module tb;
  import upc_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_WORDS = 24;
  localparam int PHASES = 6;
  localparam int LIMIT_NS = 2_000_000;
  localparam int DIR_ROWS = 26;

  // Escape tracking of the decoder.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  typedef enum logic {ROW_WORD, ROW_MODE} row_kind_e;

  // One stimulus row; n_fixed of zero leaves the expected words to the predictor.
  typedef struct packed {
    row_kind_e  kind;
    logic       mode_val;
    upc_in_t    word;
    logic [1:0] n_fixed;
    upc_out_t   r0;
    upc_out_t   r1;
    upc_out_t   r2;
  } stim_row_t;

  localparam upc_out_t NO_WORD = '0;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  upc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  upc_out_t out_data;

  // Quiet stretch: neither side idles.
  logic calm = 1'b0;

  // Predictor state.
  logic       pred_mode = MODE_ENCODE;
  logic [1:0] pred_phase = PH_IDLE;
  logic [3:0] pred_hi = 4'h0;

  upc_out_t  codec_words_q [$];
  stim_row_t row_notes_q [$];
  upc_in_t   record_q [$];
  stim_row_t dir_tab [DIR_ROWS];
  stim_row_t free_row = '0;
  int        mismatches = 0;
  int        words_seen = 0;

  url_percent_codec u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random outside the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 22);
  end

  // Value of an escape digit; bytes other than '0'..'9' count from 'A' as ten, mod 256.
  function automatic logic [7:0] digit_of(input logic [7:0] x);
    if (x >= CH_0 && x <= CH_9) begin
      return x - CH_0;
    end
    return x + 8'd10 - CH_UA;
  endfunction

  // Upper-case hex character of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CH_0 + {4'h0, n};
    end
    return CH_UA + {4'h0, n} - 8'd10;
  endfunction

  // Bytes that the encoder leaves alone.
  function automatic logic passes_plain(input logic [7:0] c);
    if (c == CH_DASH || c == CH_UNDER || c == CH_DOT) begin
      return 1'b1;
    end
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  // Works out the words one input byte causes and advances the escape state.
  task automatic codec_predict(input upc_in_t w, output int n,
                               output upc_out_t r0, output upc_out_t r1, output upc_out_t r2);
    logic [7:0] c;
    logic       lst;
    logic [7:0] dv;
    c = w.data_byte;
    lst = w.last_in;
    n = 0;
    r0 = NO_WORD;
    r1 = NO_WORD;
    r2 = NO_WORD;
    if (pred_mode == MODE_ENCODE) begin
      if (passes_plain(c)) begin
        n = 1;
        r0 = {c, lst, 1'b0};
      end else begin
        n = 3;
        r0 = {CH_PCT, 2'b00};
        r1 = {hex_char(c[7:4]), 2'b00};
        r2 = {hex_char(c[3:0]), lst, 1'b0};
      end
    end else begin
      dv = digit_of(c);
      case (pred_phase)
        PH_PCT: begin
          if (lst) begin
            // The record ended on the first digit after the percent sign.
            pred_phase = PH_IDLE;
            pred_hi = 4'h0;
            n = 1;
            r0 = {8'h00, 1'b1, 1'b1};
          end else begin
            pred_hi = dv[3:0];
            pred_phase = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          pred_phase = PH_IDLE;
          n = 1;
          r0 = {{pred_hi, 4'h0} | dv, lst, 1'b0};
          pred_hi = 4'h0;
        end
        default: begin
          pred_phase = PH_IDLE;
          if (c == CH_PCT) begin
            if (lst) begin
              pred_hi = 4'h0;
              n = 1;
              r0 = {8'h00, 1'b1, 1'b1};
            end else begin
              pred_phase = PH_PCT;
            end
          end else begin
            n = 1;
            r0 = {(c == CH_PLUS) ? CH_SPACE : c, lst, 1'b0};
          end
        end
      endcase
    end
  endtask

  // Compares one result word with the oldest expected word.
  task automatic check_word(input upc_out_t got);
    upc_out_t want;
    words_seen++;
    if (codec_words_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("word %0d: none expected, got byte %02h last %0b err %0b",
                 words_seen, got.out_byte, got.out_last, got.escape_error);
      end
    end else begin
      want = codec_words_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word %0d: byte exp %02h got %02h, last exp %0b got %0b, err exp %0b got %0b",
                   words_seen, want.out_byte, got.out_byte, want.out_last, got.out_last,
                   want.escape_error, got.escape_error);
        end
      end
    end
  endtask

  // Follows mode writes, accepted bytes and accepted result words.
  always @(posedge clk) begin
    int       n;
    upc_out_t r0;
    upc_out_t r1;
    upc_out_t r2;
    stim_row_t note;
    if (rst_n) begin
      if (cfg_we) begin
        pred_mode = cfg_wdata;
        pred_phase = PH_IDLE;
        pred_hi = 4'h0;
      end
      if (in_valid && !in_stall) begin
        note = row_notes_q.pop_front();
        codec_predict(in_data, n, r0, r1, r2);
        if (note.n_fixed != 2'd0) begin
          n = int'(note.n_fixed);
          r0 = note.r0;
          r1 = note.r1;
          r2 = note.r2;
        end
        if (n > 0) codec_words_q.insert(codec_words_q.size(), r0);
        if (n > 1) codec_words_q.insert(codec_words_q.size(), r1);
        if (n > 2) codec_words_q.insert(codec_words_q.size(), r2);
      end
      if (out_valid && !out_stall) begin
        check_word(out_data);
      end
    end
  end

  // Offers one byte, with a random gap first, and returns once it is accepted.
  task automatic push_word(input upc_in_t w, input stim_row_t note);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 22) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_notes_q.insert(row_notes_q.size(), note);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Lets every expected word come out, then gives any escape state time to settle.
  task automatic drain_codec();
    in_valid <= 1'b0;
    while (codec_words_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic append_byte(input logic [7:0] b);
    upc_in_t w;
    w.data_byte = b;
    w.last_in = 1'b0;
    record_q.insert(record_q.size(), w);
  endtask

  function automatic logic [7:0] pick_plain();
    int k;
    k = $urandom_range(64);
    if (k < 10) return CH_0 + 8'(k);
    if (k < 36) return CH_UA + 8'(k - 10);
    if (k < 62) return CH_LA + 8'(k - 36);
    if (k == 62) return CH_DASH;
    if (k == 63) return CH_UNDER;
    return CH_DOT;
  endfunction

  function automatic logic [7:0] pick_hex();
    int k;
    k = $urandom_range(21);
    if (k < 10) return CH_0 + 8'(k);
    if (k < 16) return CH_UA + 8'(k - 10);
    return CH_LA + 8'(k - 16);
  endfunction

  // One record for the encoder: unreserved bytes mixed with arbitrary ones.
  task automatic add_encode_record();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(1) == 0) append_byte(pick_plain());
      else append_byte(8'($urandom_range(255)));
    end
  endtask

  // One record for the decoder: mostly escapes, some noise, sometimes cut short.
  task automatic add_decode_record();
    int tokens;
    int pick;
    tokens = $urandom_range(1, 5);
    repeat (tokens) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        append_byte(CH_PCT);
        append_byte(pick_hex());
        append_byte(pick_hex());
      end else if (pick < 60) begin
        append_byte(CH_PLUS);
      end else if (pick < 70) begin
        append_byte(CH_PCT);
        append_byte(8'($urandom_range(255)));
        append_byte(8'($urandom_range(255)));
      end else begin
        append_byte(8'($urandom_range(255)));
      end
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      append_byte(CH_PCT);
    end else if (pick < 15) begin
      append_byte(CH_PCT);
      append_byte(pick_hex());
    end
  endtask

  // Run watchdog.
  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus sequence and final verdict.
  initial begin
    upc_in_t w;
    logic    mode_v;
    dir_tab = '{
      // Encode after reset: byte extremes, several class boundaries, and the percent sign.
      '{ROW_WORD, 1'b0, {8'h00, 1'b0}, 2'd3, {CH_PCT, 2'b00}, {CH_0, 2'b00}, {CH_0, 2'b00}},
      '{ROW_WORD, 1'b0, {8'hFF, 1'b1}, 2'd3, {CH_PCT, 2'b00}, {8'h46, 2'b00}, {8'h46, 2'b10}},
      '{ROW_WORD, 1'b0, {CH_DASH, 1'b0}, 2'd1, {CH_DASH, 2'b00}, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_UNDER, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_DOT, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h2F, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_9, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h40, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_UZ, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h60, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_LZ, 1'b1}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_PCT, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      // Decode: plus sign, escapes with upper and lower case digits.
      '{ROW_MODE, MODE_DECODE, 9'h0, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_PLUS, 1'b0}, 2'd1, {CH_SPACE, 2'b00}, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_PCT, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h34, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h31, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_PCT, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h66, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h46, 1'b1}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      // A record that ends on the percent sign, then one that ends on the first digit.
      '{ROW_WORD, 1'b0, {CH_PCT, 1'b1}, 2'd1, {8'h00, 2'b11}, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {CH_PCT, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h33, 1'b1}, 2'd1, {8'h00, 2'b11}, NO_WORD, NO_WORD},
      // A mode write in the middle of an escape drops it.
      '{ROW_WORD, 1'b0, {CH_PCT, 1'b0}, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_MODE, MODE_DECODE, 9'h0, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_WORD, 1'b0, {8'h34, 1'b1}, 2'd1, {8'h34, 2'b10}, NO_WORD, NO_WORD}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_MODE) begin
        drain_codec();
        write_mode(dir_tab[i].mode_val);
      end else begin
        push_word(dir_tab[i].word, dir_tab[i]);
      end
    end

    // Random phases, each under one mode setting; the third one runs without idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      mode_v = (ph < 2) ? ph[0] : 1'($urandom_range(1));
      drain_codec();
      write_mode(mode_v);
      calm = (ph == 2);
      while (record_q.size() < PHASE_WORDS) begin
        if (mode_v == MODE_DECODE) add_decode_record();
        else add_encode_record();
        w = record_q.pop_back();
        w.last_in = 1'b1;
        record_q.insert(record_q.size(), w);
      end
      while (record_q.size() != 0) begin
        push_word(record_q.pop_front(), free_row);
      end
    end
    calm = 1'b0;

    drain_codec();
    if (codec_words_q.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
